/* rtl/core/sorted_list_table_macros.svh */
// Assertion macros shared by the sorted list table RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SORTED_LIST_TABLE_MACROS_SVH
`define SORTED_LIST_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SLT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list table check failed");

`define SLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list table check failed");

`else

`define SLT_ASSERT_SAME(label, ante, cons)

`define SLT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/slt_pkg.sv */
`default_nettype none

package slt_pkg;

  // Table geometry.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the command and response beats.
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 6;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int FOUND_W   = 4;
  localparam int COUNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 2'd0,
    CMD_FIND       = 2'd1,
    CMD_REMOVE_AT  = 2'd2,
    CMD_REMOVE_VAL = 2'd3
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic compare;
    logic commit;
  } dp_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/slt_interfaces.sv */
`default_nettype none

// Command channel: one beat carries one table command.
interface slt_cmd_if;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic signed [31:0]  value;
  logic signed [5:0]   position;

  modport source (output valid, output command, output value, output position, input ready);
  modport sink (input valid, input command, input value, input position, output ready);
endinterface

// Response channel: one beat per command.
interface slt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  found_position;
  logic [4:0]  entry_count;

  modport source (output valid, output status, output found_position, output entry_count,
                  input ready);
  modport sink (input valid, input status, input found_position, input entry_count,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/slt_ctrl.sv */
`default_nettype none

`include "sorted_list_table_macros.svh"

module slt_ctrl
  import slt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_ctrl_t      ctrl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   commit;

  // A new command is taken whenever the datapath is free; the response
  // register holds the previous answer independently.
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_EXEC) && (!out_valid || out_ready);

  assign ctrl.load    = accept;
  assign ctrl.compare = (state == S_CMP);
  assign ctrl.commit  = commit;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A committed command always leaves a response waiting in the next cycle.
  `SLT_ASSERT_NEXT(a_commit_gives_rsp, commit, out_valid)
  // A response only appears straight after a commit.
  `SLT_ASSERT_SAME(a_rsp_from_commit, $rose(out_valid), $past(commit))
  // The compare cycle always follows an accepted command.
  `SLT_ASSERT_SAME(a_cmp_after_accept, state == S_CMP, $past(accept))

endmodule

`default_nettype wire

/* rtl/core/slt_datapath.sv */
`default_nettype none

module slt_datapath
  import slt_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire dp_ctrl_t                    ctrl,
  input  wire logic [CMD_W-1:0]            command,
  input  wire logic signed [VALUE_W-1:0]   value,
  input  wire logic signed [POS_W-1:0]     position,
  output logic [STATUS_W-1:0]              status,
  output logic [FOUND_W-1:0]               found_position,
  output logic [COUNT_W-1:0]               entry_count
);

  // Captured command.
  command_t                   cmd_q;
  logic signed [VALUE_W-1:0]  value_q;
  logic signed [POS_W-1:0]    pos_q;

  // Table storage, kept in ascending order below count.
  logic signed [VALUE_W-1:0]  entries [CAPACITY];
  logic [CNT_W-1:0]           count;

  // Per-entry compare flags.
  logic [CAPACITY-1:0]        lt_now;
  logic [CAPACITY-1:0]        eq_now;
  logic [CAPACITY-1:0]        lt_q;
  logic [CAPACITY-1:0]        eq_q;

  // Execution decisions.
  logic [IDX_W-1:0]           lb;
  logic                       lb_ok;
  logic                       hit;
  logic                       pos_ok;
  logic                       do_ins;
  logic                       do_del;
  logic [IDX_W-1:0]           del_idx;
  status_t                    status_n;
  logic [FOUND_W-1:0]         found_n;
  logic [CNT_W-1:0]           count_n;

  // Result register.
  status_t                    status_q;
  logic [FOUND_W-1:0]         found_q;
  logic [CNT_W-1:0]           count_out_q;

  // Capture the command beat.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q   <= command_t'(command);
      value_q <= value;
      pos_q   <= position;
    end
  end

  // Every live entry is compared against the value at once.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_now[i] = (i < int'(count)) && (entries[i] < value_q);
      eq_now[i] = (i < int'(count)) && (entries[i] == value_q);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      lt_q <= lt_now;
      eq_q <= eq_now;
    end
  end

  // The less-than flags form a run of ones from the bottom, so the insertion
  // point is the lowest clear flag.
  always_comb begin
    lb    = '0;
    lb_ok = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!lt_q[i]) begin
        lb    = IDX_W'(i);
        lb_ok = 1'b1;
      end
    end
  end

  assign hit     = lb_ok && eq_q[lb];
  assign pos_ok  = !pos_q[POS_W-1] && (int'(pos_q[POS_W-2:0]) < int'(count));

  // Command decode and outcome.
  always_comb begin
    do_ins   = 1'b0;
    do_del   = 1'b0;
    del_idx  = lb;
    status_n = ST_OK;
    found_n  = '0;
    count_n  = count;
    if (cmd_q == CMD_INSERT) begin
      if (int'(count) >= CAPACITY) begin
        status_n = ST_FULL;
      end else begin
        do_ins  = 1'b1;
        count_n = count + CNT_W'(1);
      end
    end else if (count == '0) begin
      status_n = ST_EMPTY;
    end else if (cmd_q == CMD_REMOVE_AT) begin
      if (pos_ok) begin
        do_del  = 1'b1;
        del_idx = pos_q[IDX_W-1:0];
        count_n = count - CNT_W'(1);
      end else begin
        status_n = ST_MISS;
      end
    end else begin
      if (hit) begin
        if (cmd_q == CMD_FIND) begin
          found_n = FOUND_W'(lb);
        end else begin
          do_del  = 1'b1;
          count_n = count - CNT_W'(1);
        end
      end else begin
        status_n = ST_MISS;
      end
    end
  end

  // Each slot holds, moves up, moves down or takes the new value on commit.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    logic signed [VALUE_W-1:0] from_below;
    logic signed [VALUE_W-1:0] from_above;

    if (g == 0) begin : g_first
      assign from_below = value_q;
    end else begin : g_rest
      assign from_below = entries[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign from_above = entries[g];
    end else begin : g_inner
      assign from_above = entries[g+1];
    end

    always_ff @(posedge clk) begin
      if (ctrl.commit) begin
        if (do_ins) begin
          if (g > int'(lb)) begin
            entries[g] <= from_below;
          end else if (g == int'(lb)) begin
            entries[g] <= value_q;
          end
        end else if (do_del && (g >= int'(del_idx))) begin
          entries[g] <= from_above;
        end
      end
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.commit) begin
      count <= count_n;
    end
  end

  // Response payload.
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      status_q    <= status_n;
      found_q     <= found_n;
      count_out_q <= count_n;
    end
  end

  assign status         = status_q;
  assign found_position = found_q;
  assign entry_count    = COUNT_W'(count_out_q);

endmodule

`default_nettype wire

/* rtl/core/sorted_list_table.sv */
// Sorted list table: holds up to CAPACITY (16) signed 32-bit values in
// ascending order and answers one command per cmd beat with exactly one rsp
// beat. Commands are insert, find, remove at position and remove by value;
// each answer gives a status (ok, empty, not found or bad position, full), the
// position found by a find and the entry count afterwards. An insert into a
// full table is dropped with status full. Every command passes through these
// steps in order: it is accepted and captured, all live entries are compared
// against the value in parallel, and then the whole table shifts in a single
// step and the response register is loaded, a step that stalls while the
// previous response has not been taken; the response waits from the cycle
// after the load. A new command can be accepted while the previous response
// still waits, but no new command is taken until the last one is through.
// No clearing pass is needed after reset.

`default_nettype none

module sorted_list_table
  import slt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  slt_cmd_if.sink      cmd,
  slt_rsp_if.source    rsp
);

  dp_ctrl_t ctrl;

  slt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctrl      (ctrl)
  );

  slt_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .command        (cmd.command),
    .value          (cmd.value),
    .position       (cmd.position),
    .status         (rsp.status),
    .found_position (rsp.found_position),
    .entry_count    (rsp.entry_count)
  );

endmodule

`default_nettype wire
